### src/ptlf_pkg.sv
// Shared types, constants and the zone scoring function for the peer table block.
package ptlf_pkg;

  localparam int MAX_PEERS_DEF = 8;
  localparam int NUM_ZONES_DEF = 4;

  localparam logic [15:0] MAGIC_WORD = 16'hA61B;
  localparam logic [7:0]  PAIR_TYPE  = 8'd5;
  localparam logic [9:0]  ZONE_BONUS = 10'd100;

  localparam logic [31:0] RESET_TIMEOUT_US = 32'd3000000;
  localparam logic [31:0] RESET_WINDOW_US  = 32'd30000000;

  localparam logic [1:0] MODE_MSG   = 2'd0;
  localparam logic [1:0] MODE_SWEEP = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_PAIR  = 2'd3;

  localparam logic [1:0] FUSE_NEWEST   = 2'd0;
  localparam logic [1:0] FUSE_NONCOORD = 2'd1;
  localparam logic [1:0] FUSE_COORD    = 2'd2;
  localparam logic [1:0] FUSE_ZONE     = 2'd3;

  localparam logic [2:0] REG_OWN_MAC    = 3'd0;
  localparam logic [2:0] REG_FUSION     = 3'd1;
  localparam logic [2:0] REG_TIMEOUT    = 3'd2;
  localparam logic [2:0] REG_WINDOW     = 3'd3;
  localparam logic [2:0] REG_ZONE_COUNT = 3'd4;
  localparam logic [2:0] REG_ZONES_LOW  = 3'd5;
  localparam logic [2:0] REG_ZONES_HIGH = 3'd6;

  typedef struct packed {
    logic signed [15:0] cm;
    logic signed [7:0]  dir;
    logic [7:0]         en;
  } reading_t;

  typedef struct packed {
    logic [47:0] mac;
    logic [47:0] ts;
    reading_t    rd;
  } entry_t;

  function automatic logic [9:0] zone_score(logic signed [15:0] d, logic [7:0] en,
                                            logic [2:0] zc, logic [63:0] lo_w,
                                            logic [63:0] hi_w);
    logic [127:0] w;
    logic signed [15:0] zl;
    logic signed [15:0] zh;
    logic [9:0] s;
    w = {hi_w, lo_w};
    s = {2'b00, en};
    for (int z = 0; z < 4; z++) begin
      zl = w[z*32 +: 16];
      zh = w[z*32+16 +: 16];
      if (3'(z) < zc && zh != 16'sd0 && d >= zl && d <= zh) begin
        s = s + ZONE_BONUS;
      end
    end
    return s;
  endfunction

endpackage

### src/peer_table_leader_and_fusion.sv
// Peer table with coordinator election and reading fusion, top level.
//
// channel | signals                                   | handshake
// --------+-------------------------------------------+--------------------------
// request | start, busy, mode .. local_ts_us          | taken when start & !busy
// result  | done, coordinator .. fused_present        | one-cycle strobe on done
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data | taken when valid & ready
//
// A request goes from idle to S_FIN; one that walks the table (message, sweep, query)
// first passes S_READ and S_EVAL: one memory read and one evaluation per entry
// through the single read port of the entry memory. Pairing and messages that
// fail the header checks skip the walk. Reset is synchronous and clears control
// state only; there is no clearing pass. The receiver cannot stall the result strobe.
module peer_table_leader_and_fusion #(
  parameter int MAX_PEERS = ptlf_pkg::MAX_PEERS_DEF,
  parameter int NUM_ZONES = ptlf_pkg::NUM_ZONES_DEF,
  parameter int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1,
  parameter int CW = $clog2(MAX_PEERS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic [47:0]        now_us,
  input  logic [47:0]        src_mac,
  input  logic               length_ok,
  input  logic [15:0]        msg_magic,
  input  logic [7:0]         frame_type,
  input  logic signed [15:0] target_cm,
  input  logic signed [7:0]  direction,
  input  logic [7:0]         energy,
  input  logic [47:0]        local_ts_us,
  output logic               done,
  output logic               coordinator,
  output logic [CW-1:0]      peers,
  output logic               msg_accepted,
  output logic signed [15:0] fused_distance_cm,
  output logic signed [7:0]  fused_direction,
  output logic [7:0]         fused_energy,
  output logic               fused_present,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [47:0] own_mac;
  logic [1:0]  fusion_mode;
  logic [31:0] stale_timeout_us;
  logic [31:0] pairing_window_us;
  logic [2:0]  zone_count;
  logic [63:0] zone_windows_low;
  logic [63:0] zone_windows_high;

  logic [1:0]  state;
  logic [IW-1:0] idx;
  logic [CW-1:0] total;
  logic [MAX_PEERS-1:0] healthy;
  logic        coord;
  logic [47:0] deadline;

  logic [1:0]  req_mode;
  logic [47:0] req_now;
  logic [47:0] req_src;
  logic [7:0]  req_type;
  logic        msg_ok;
  ptlf_pkg::reading_t req_rd;

  logic        found;
  logic [IW-1:0] fidx;
  logic [47:0] best;

  logic [47:0] n_ts;
  ptlf_pkg::reading_t n_rd;
  logic        r_found;
  logic [47:0] r_ts;
  ptlf_pkg::reading_t r_rd;
  logic [9:0]  z_score;
  ptlf_pkg::reading_t z_rd;

  ptlf_pkg::entry_t mem [MAX_PEERS];
  ptlf_pkg::entry_t rdata;
  logic        mem_we;
  logic [IW-1:0] mem_waddr;
  ptlf_pkg::entry_t mem_wdata;

  logic [2:0]  zc;
  logic [47:0] age;
  logic        fresh;
  logic        live;
  logic        last;
  logic        want;
  logic        cand_coord;
  logic [9:0]  cand_score;
  logic        in_check;
  logic        add_ok;
  logic        wrote;
  logic        room;
  logic [47:0] best_fin;
  ptlf_pkg::reading_t pick;

  assign cfg_ready = 1'b1;
  assign busy = (state != S_IDLE);
  assign coordinator = coord;
  assign peers = total;

  assign zc = (zone_count > 3'(NUM_ZONES)) ? 3'(NUM_ZONES) : zone_count;
  assign age = req_now - rdata.ts;
  assign fresh = !(age > {16'b0, stale_timeout_us});
  assign live = age < {16'b0, stale_timeout_us};
  assign last = (CW'(idx) + CW'(1)) == total;
  assign want = (fusion_mode == ptlf_pkg::FUSE_COORD);
  assign cand_coord = rdata.mac < own_mac;
  assign cand_score = ptlf_pkg::zone_score(rdata.rd.cm, rdata.rd.en, zc,
                                           zone_windows_low, zone_windows_high);
  assign in_check = length_ok && msg_magic == ptlf_pkg::MAGIC_WORD && src_mac != own_mac;
  assign add_ok = found || req_now < deadline || req_type == ptlf_pkg::PAIR_TYPE;
  assign room = total < CW'(MAX_PEERS);
  assign wrote = found || (add_ok && room);
  assign best_fin = (wrote && req_src < best) ? req_src : best;

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = found ? fidx : total[IW-1:0];
    mem_wdata.mac = req_src;
    mem_wdata.ts = req_now;
    mem_wdata.rd = req_rd;
    if (state == S_FIN && req_mode == ptlf_pkg::MODE_MSG && msg_ok && wrote) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    case (fusion_mode)
      ptlf_pkg::FUSE_NEWEST: pick = n_rd;
      ptlf_pkg::FUSE_NONCOORD, ptlf_pkg::FUSE_COORD: pick = r_found ? r_rd : n_rd;
      ptlf_pkg::FUSE_ZONE: pick = z_rd;
      default: pick = n_rd;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= 48'd0;
      fusion_mode <= ptlf_pkg::FUSE_NEWEST;
      stale_timeout_us <= ptlf_pkg::RESET_TIMEOUT_US;
      pairing_window_us <= ptlf_pkg::RESET_WINDOW_US;
      zone_count <= 3'd0;
      zone_windows_low <= 64'd0;
      zone_windows_high <= 64'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ptlf_pkg::REG_OWN_MAC:    own_mac <= cfg_data[47:0];
        ptlf_pkg::REG_FUSION:     fusion_mode <= cfg_data[1:0];
        ptlf_pkg::REG_TIMEOUT:    stale_timeout_us <= cfg_data[31:0];
        ptlf_pkg::REG_WINDOW:     pairing_window_us <= cfg_data[31:0];
        ptlf_pkg::REG_ZONE_COUNT: zone_count <= cfg_data[2:0];
        ptlf_pkg::REG_ZONES_LOW:  zone_windows_low <= cfg_data;
        ptlf_pkg::REG_ZONES_HIGH: zone_windows_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      total <= '0;
      healthy <= '0;
      coord <= 1'b1;
      deadline <= {16'b0, ptlf_pkg::RESET_WINDOW_US};
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req_mode <= mode;
            req_now <= now_us;
            req_src <= src_mac;
            req_type <= frame_type;
            req_rd.cm <= target_cm;
            req_rd.dir <= direction;
            req_rd.en <= energy;
            msg_ok <= in_check;
            found <= 1'b0;
            fidx <= '0;
            best <= own_mac;
            idx <= '0;
            n_ts <= local_ts_us;
            n_rd <= '{target_cm, direction, energy};
            r_found <= (coord == want) && energy != 8'd0 && local_ts_us != 48'd0;
            r_ts <= ((coord == want) && energy != 8'd0) ? local_ts_us : 48'd0;
            r_rd <= '{target_cm, direction, energy};
            z_score <= ptlf_pkg::zone_score(target_cm, energy, zc,
                                            zone_windows_low, zone_windows_high);
            z_rd <= '{target_cm, direction, energy};
            if (mode == ptlf_pkg::MODE_PAIR) begin
              deadline <= now_us + {16'b0, pairing_window_us};
              state <= S_FIN;
            end else if ((mode == ptlf_pkg::MODE_MSG && !in_check) || total == '0) begin
              state <= S_FIN;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          case (req_mode)
            ptlf_pkg::MODE_MSG: begin
              if (!found && rdata.mac == req_src) begin
                found <= 1'b1;
                fidx <= idx;
              end
              if (healthy[idx] && fresh && rdata.mac < best) begin
                best <= rdata.mac;
              end
            end
            ptlf_pkg::MODE_SWEEP: begin
              healthy[idx] <= live;
              if (live && rdata.mac < best) begin
                best <= rdata.mac;
              end
            end
            ptlf_pkg::MODE_QUERY: begin
              if (healthy[idx]) begin
                if (rdata.ts > n_ts) begin
                  n_ts <= rdata.ts;
                  n_rd <= rdata.rd;
                end
                if (cand_coord == want && rdata.rd.en != 8'd0 && rdata.ts > r_ts) begin
                  r_found <= 1'b1;
                  r_ts <= rdata.ts;
                  r_rd <= rdata.rd;
                end
                if (cand_score > z_score) begin
                  z_score <= cand_score;
                  z_rd <= rdata.rd;
                end
              end
            end
            default: ;
          endcase
          if (last) begin
            state <= S_FIN;
          end else begin
            idx <= idx + IW'(1);
            state <= S_READ;
          end
        end
        S_FIN: begin
          done <= 1'b1;
          msg_accepted <= 1'b0;
          fused_distance_cm <= 16'sd0;
          fused_direction <= 8'sd0;
          fused_energy <= 8'd0;
          fused_present <= 1'b0;
          case (req_mode)
            ptlf_pkg::MODE_MSG: begin
              if (msg_ok && add_ok) begin
                coord <= (best_fin == own_mac);
                msg_accepted <= wrote;
                if (wrote) begin
                  healthy[mem_waddr] <= 1'b1;
                end
                if (!found && room) begin
                  total <= total + CW'(1);
                end
              end
            end
            ptlf_pkg::MODE_SWEEP: begin
              coord <= (best == own_mac);
            end
            ptlf_pkg::MODE_QUERY: begin
              fused_distance_cm <= pick.cm;
              fused_direction <= pick.dir;
              fused_energy <= pick.en;
              fused_present <= (pick.en != 8'd0);
            end
            default: ;
          endcase
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### tb/tb_top.sv
// Self-checking testbench for the peer table, coordinator election and reading fusion block.
module tb_top;

  localparam int  PHASES      = 8;
  localparam int  PHASE_ITEMS = 210;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]         mode;
    logic [47:0]        now;
    logic [47:0]        src;
    logic               lok;
    logic [15:0]        magic;
    logic [7:0]         typ;
    logic signed [15:0] cm;
    logic signed [7:0]  dir;
    logic [7:0]         en;
    logic [47:0]        lts;
  } request_t;

  typedef struct packed {
    logic               coord;
    logic [3:0]         count;
    logic               acc;
    logic signed [15:0] fd;
    logic signed [7:0]  fdir;
    logic [7:0]         fen;
    logic               fpres;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] mode = '0;
  logic [47:0] now_us = '0;
  logic [47:0] src_mac = '0;
  logic length_ok = 1'b0;
  logic [15:0] msg_magic = '0;
  logic [7:0] frame_type = '0;
  logic signed [15:0] target_cm = '0;
  logic signed [7:0] direction = '0;
  logic [7:0] energy = '0;
  logic [47:0] local_ts_us = '0;
  logic done;
  logic coordinator;
  logic [3:0] peers;
  logic msg_accepted;
  logic signed [15:0] fused_distance_cm;
  logic signed [7:0] fused_direction;
  logic [7:0] fused_energy;
  logic fused_present;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  peer_table_leader_and_fusion u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode), .now_us(now_us),
    .src_mac(src_mac), .length_ok(length_ok), .msg_magic(msg_magic),
    .frame_type(frame_type), .target_cm(target_cm), .direction(direction),
    .energy(energy), .local_ts_us(local_ts_us), .done(done), .coordinator(coordinator),
    .peers(peers), .msg_accepted(msg_accepted),
    .fused_distance_cm(fused_distance_cm), .fused_direction(fused_direction),
    .fused_energy(fused_energy), .fused_present(fused_present), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // model copy of registers and peer table
  logic [47:0] own_mac_r;
  logic [1:0]  fusion_r;
  logic [31:0] timeout_r;
  logic [31:0] window_r;
  logic [2:0]  zcount_r;
  logic [63:0] zlow_r;
  logic [63:0] zhigh_r;
  logic [47:0] tbl_mac [ptlf_pkg::MAX_PEERS_DEF];
  logic [47:0] tbl_seen [ptlf_pkg::MAX_PEERS_DEF];
  logic        tbl_ok [ptlf_pkg::MAX_PEERS_DEF];
  ptlf_pkg::reading_t tbl_rd [ptlf_pkg::MAX_PEERS_DEF];
  int          tbl_total;
  logic        coord_bit;
  logic [47:0] pair_deadline;

  request_t request_queue[$];
  outcome_t expected_outcomes[$];
  request_t cur_req;
  int idle_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;
  logic [47:0] mac_pool [12];
  logic [47:0] sim_now = '0;

  function automatic logic [47:0] age_of(logic [47:0] now, int i);
    return (now - tbl_seen[i]) & MASK48;
  endfunction

  function automatic void run_election(logic [47:0] now);
    logic [47:0] best;
    best = own_mac_r;
    for (int i = 0; i < tbl_total; i++) begin
      if (tbl_ok[i] && age_of(now, i) <= {16'd0, timeout_r} && tbl_mac[i] < best) begin
        best = tbl_mac[i];
      end
    end
    coord_bit = (best == own_mac_r);
  endfunction

  function automatic int zone_points(ptlf_pkg::reading_t r);
    int score;
    int lim;
    logic [127:0] w;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    w = {zhigh_r, zlow_r};
    score = int'(r.en);
    lim = (zcount_r < 4) ? int'(zcount_r) : 4;
    for (int z = 0; z < lim; z++) begin
      lo = w[z*32 +: 16];
      hi = w[z*32+16 +: 16];
      if (hi != 0 && int'(r.cm) >= int'(lo) && int'(r.cm) <= int'(hi)) score += 100;
    end
    return score;
  endfunction

  function automatic outcome_t predict_peer_step(request_t q);
    outcome_t o;
    ptlf_pkg::reading_t cr [ptlf_pkg::MAX_PEERS_DEF+1];
    logic [47:0] cts [ptlf_pkg::MAX_PEERS_DEF+1];
    logic ccoord [ptlf_pkg::MAX_PEERS_DEF+1];
    int n;
    int idx;
    int pick;
    int top_score;
    int sc;
    logic [47:0] t;
    logic go;
    o = '0;
    case (q.mode)
      ptlf_pkg::MODE_MSG: begin
        if (q.lok && q.magic == ptlf_pkg::MAGIC_WORD && q.src != own_mac_r) begin
          idx = -1;
          go = 1'b1;
          for (int i = 0; i < tbl_total; i++) if (idx < 0 && tbl_mac[i] == q.src) idx = i;
          if (idx < 0) begin
            if (q.now < pair_deadline || q.typ == ptlf_pkg::PAIR_TYPE) begin
              if (tbl_total < ptlf_pkg::MAX_PEERS_DEF) begin
                idx = tbl_total;
                tbl_mac[idx] = q.src;
                tbl_total++;
              end
            end else begin
              go = 1'b0;
            end
          end
          if (go) begin
            if (idx >= 0) begin
              tbl_rd[idx] = '{cm: q.cm, dir: q.dir, en: q.en};
              tbl_seen[idx] = q.now;
              tbl_ok[idx] = 1'b1;
              o.acc = 1'b1;
            end
            run_election(q.now);
          end
        end
      end
      ptlf_pkg::MODE_SWEEP: begin
        for (int i = 0; i < tbl_total; i++) tbl_ok[i] = age_of(q.now, i) < {16'd0, timeout_r};
        run_election(q.now);
      end
      ptlf_pkg::MODE_QUERY: begin
        cr[0] = '{cm: q.cm, dir: q.dir, en: q.en};
        cts[0] = q.lts;
        ccoord[0] = coord_bit;
        n = 1;
        for (int i = 0; i < tbl_total; i++) begin
          if (tbl_ok[i]) begin
            cr[n] = tbl_rd[i];
            cts[n] = tbl_seen[i];
            ccoord[n] = tbl_mac[i] < own_mac_r;
            n++;
          end
        end
        pick = -1;
        if (fusion_r == ptlf_pkg::FUSE_NONCOORD || fusion_r == ptlf_pkg::FUSE_COORD) begin
          t = '0;
          for (int i = 0; i < n; i++) begin
            if (ccoord[i] == (fusion_r == ptlf_pkg::FUSE_COORD) && cr[i].en != 0 &&
                cts[i] > t) begin
              t = cts[i];
              pick = i;
            end
          end
        end else if (fusion_r == ptlf_pkg::FUSE_ZONE) begin
          top_score = -1;
          for (int i = 0; i < n; i++) begin
            sc = zone_points(cr[i]);
            if (sc > top_score) begin
              top_score = sc;
              pick = i;
            end
          end
        end
        if (pick < 0) begin
          pick = 0;
          t = '0;
          for (int i = 0; i < n; i++) begin
            if (cts[i] > t) begin
              t = cts[i];
              pick = i;
            end
          end
        end
        o.fd = cr[pick].cm;
        o.fdir = cr[pick].dir;
        o.fen = cr[pick].en;
        o.fpres = cr[pick].en != 0;
      end
      default: pair_deadline = (q.now + {16'd0, window_r}) & MASK48;
    endcase
    o.coord = coord_bit;
    o.count = 4'(tbl_total);
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_outcomes.push_back(predict_peer_step(cur_req));
      if (!start || !busy) begin
        if (request_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur_req = request_queue.pop_front();
          start <= 1'b1;
          mode <= cur_req.mode;
          now_us <= cur_req.now;
          src_mac <= cur_req.src;
          length_ok <= cur_req.lok;
          msg_magic <= cur_req.magic;
          frame_type <= cur_req.typ;
          target_cm <= cur_req.cm;
          direction <= cur_req.dir;
          energy <= cur_req.en;
          local_ts_us <= cur_req.lts;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    outcome_t e;
    if (!rst && done) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t unexpected result strobe, expected none, actual coord %0d count %0d",
                 $time, coordinator, peers);
        fail_count++;
      end else begin
        e = expected_outcomes.pop_front();
        check_field("coordinator", e.coord, coordinator);
        check_field("peers", e.count, peers);
        check_field("msg_accepted", e.acc, msg_accepted);
        check_field("fused_distance_cm", e.fd, fused_distance_cm);
        check_field("fused_direction", e.fdir, fused_direction);
        check_field("fused_energy", e.fen, fused_energy);
        check_field("fused_present", e.fpres, fused_present);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic logic [63:0] zone_word();
    logic [63:0] w;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    for (int z = 0; z < 2; z++) begin
      lo = 16'($urandom_range(600)) - 16'sd300;
      hi = lo + 16'($urandom_range(300));
      if ($urandom_range(5) == 0) hi = '0;
      if ($urandom_range(7) == 0) begin
        lo = 16'($urandom);
        hi = 16'($urandom);
      end
      w[z*32 +: 32] = {hi, lo};
    end
    return w;
  endfunction

  function automatic request_t build_request(logic [1:0] m);
    request_t q;
    int r;
    q = '0;
    q.mode = m;
    r = $urandom_range(99);
    if (r < 70) sim_now = (sim_now + 48'($urandom_range(500000))) & MASK48;
    else if (r < 90) sim_now = (sim_now + 48'($urandom_range(5000000))) & MASK48;
    else if (r < 97) sim_now = (sim_now + 48'($urandom)) & MASK48;
    else sim_now = rand48();
    q.now = sim_now;
    q.src = ($urandom_range(9) == 0) ? rand48() : mac_pool[$urandom_range(11)];
    if ($urandom_range(19) == 0) q.src = own_mac_r;
    q.lok = $urandom_range(19) != 0;
    q.magic = ($urandom_range(11) == 0) ? 16'($urandom) : ptlf_pkg::MAGIC_WORD;
    q.typ = ($urandom_range(4) == 0) ? ptlf_pkg::PAIR_TYPE : 8'($urandom);
    q.cm = ($urandom_range(1) == 0) ? 16'($urandom_range(700)) - 16'sd350 : 16'($urandom);
    q.dir = 8'($urandom);
    q.en = ($urandom_range(5) == 0) ? 8'd0 : 8'($urandom);
    r = $urandom_range(9);
    q.lts = (r < 2) ? 48'd0 : (r < 6) ? sim_now : rand48();
    return q;
  endfunction

  function automatic logic [1:0] pick_mode();
    int r;
    r = $urandom_range(99);
    return (r < 50) ? ptlf_pkg::MODE_MSG : (r < 65) ? ptlf_pkg::MODE_SWEEP :
           (r < 90) ? ptlf_pkg::MODE_QUERY : ptlf_pkg::MODE_PAIR;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ptlf_pkg::REG_OWN_MAC:    own_mac_r = val[47:0];
      ptlf_pkg::REG_FUSION:     fusion_r = val[1:0];
      ptlf_pkg::REG_TIMEOUT:    timeout_r = val[31:0];
      ptlf_pkg::REG_WINDOW:     window_r = val[31:0];
      ptlf_pkg::REG_ZONE_COUNT: zcount_r = val[2:0];
      ptlf_pkg::REG_ZONES_LOW:  zlow_r = val;
      default:                  zhigh_r = val;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (request_queue.size() != 0 || start || expected_outcomes.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    request_t q;
    logic [47:0] om;
    own_mac_r = '0;
    fusion_r = ptlf_pkg::FUSE_NEWEST;
    timeout_r = ptlf_pkg::RESET_TIMEOUT_US;
    window_r = ptlf_pkg::RESET_WINDOW_US;
    zcount_r = '0;
    zlow_r = '0;
    zhigh_r = '0;
    tbl_total = 0;
    coord_bit = 1'b1;
    pair_deadline = 48'(ptlf_pkg::RESET_WINDOW_US);
    for (int i = 0; i < ptlf_pkg::MAX_PEERS_DEF; i++) tbl_ok[i] = 1'b0;
    mac_pool[0] = '0;
    mac_pool[1] = MASK48;
    for (int i = 2; i < 12; i++) mac_pool[i] = rand48();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, rejects, pairing, extremes
    q = build_request(ptlf_pkg::MODE_QUERY); q.lts = '0; q.cm = 16'sh7FFF; q.dir = 8'sh7F;
    q.en = 8'hFF; q.now = '0; request_queue.push_back(q);
    q = build_request(ptlf_pkg::MODE_QUERY); q.lts = MASK48; q.cm = 16'sh8000;
    q.dir = 8'sh80; q.en = '0; request_queue.push_back(q);
    q = build_request(ptlf_pkg::MODE_MSG); q.now = 48'd100; q.lok = 1'b0;
    q.src = mac_pool[3]; q.magic = ptlf_pkg::MAGIC_WORD; request_queue.push_back(q);
    q.lok = 1'b1; q.magic = ~ptlf_pkg::MAGIC_WORD; request_queue.push_back(q);
    q.magic = ptlf_pkg::MAGIC_WORD; q.src = '0; request_queue.push_back(q);
    for (int i = 1; i < 11; i++) begin
      q = build_request(ptlf_pkg::MODE_MSG); q.now = 48'(i * 1000); q.src = mac_pool[i];
      q.lok = 1'b1; q.magic = ptlf_pkg::MAGIC_WORD; request_queue.push_back(q);
    end
    q = build_request(ptlf_pkg::MODE_SWEEP); q.now = 48'd4000000; request_queue.push_back(q);
    q = build_request(ptlf_pkg::MODE_MSG); q.now = 48'd40000000; q.src = mac_pool[11];
    q.lok = 1'b1; q.magic = ptlf_pkg::MAGIC_WORD; q.typ = 8'd7; request_queue.push_back(q);
    q.typ = ptlf_pkg::PAIR_TYPE; request_queue.push_back(q);
    q = build_request(ptlf_pkg::MODE_PAIR); q.now = MASK48; request_queue.push_back(q);
    q = build_request(ptlf_pkg::MODE_MSG); q.now = 48'd10; q.src = mac_pool[2];
    q.lok = 1'b1; q.magic = ptlf_pkg::MAGIC_WORD; request_queue.push_back(q);
    q = build_request(ptlf_pkg::MODE_QUERY); q.now = 48'd20; request_queue.push_back(q);
    sim_now = 48'd20;
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      om = (ph == 1) ? 48'd0 : (ph == 2) ? MASK48 :
           ($urandom_range(2) == 0) ? rand48() : mac_pool[$urandom_range(11)];
      write_reg(ptlf_pkg::REG_OWN_MAC, {16'd0, om});
      write_reg(ptlf_pkg::REG_FUSION, 64'(ph % 4));
      write_reg(ptlf_pkg::REG_TIMEOUT, (ph == 1) ? 64'd1 : (ph == 2) ? 64'hFFFF_FFFF :
                (ph == 3) ? 64'd500000 : 64'($urandom_range(4000000, 200000)));
      write_reg(ptlf_pkg::REG_WINDOW, (ph == 0) ? 64'd0 : (ph == 2) ? 64'hFFFF_FFFF :
                64'($urandom_range(20000000)));
      write_reg(ptlf_pkg::REG_ZONE_COUNT, (ph == 3) ? 64'd4 : (ph == 7) ? 64'd7 :
                64'($urandom_range(7)));
      write_reg(ptlf_pkg::REG_ZONES_LOW, (ph == 5) ? {$urandom, $urandom} : zone_word());
      write_reg(ptlf_pkg::REG_ZONES_HIGH, zone_word());
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 71 : 37;
      for (int k = 0; k < PHASE_ITEMS; k++) request_queue.push_back(build_request(pick_mode()));
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
